### src/tcc_pkg.sv
// Shared types, codes, defaults and the note frequency table of the tone command controller.
`default_nettype none
package tcc_pkg;

    // Action codes carried on the input word
    localparam logic [2:0] ACT_PLAY = 3'd0;
    localparam logic [2:0] ACT_STOP = 3'd1;
    localparam logic [2:0] ACT_BEEP = 3'd2;
    localparam logic [2:0] ACT_NOTE = 3'd3;
    localparam logic [2:0] ACT_TICK = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_CLOCK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TONE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_HZ   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS   = 3'd4;
    localparam int CFG_DATA_W = 24;

    // Register reset values
    localparam logic [23:0] REF_CLOCK_RST = 24'd1193180;
    localparam logic [15:0] MAX_TONE_RST  = 16'd20000;
    localparam logic [15:0] BEEP_HZ_RST   = 16'd750;
    localparam logic [15:0] BEEP_MS_RST   = 16'd100;
    localparam logic [9:0]  TICK_MS_RST   = 10'd10;

    // Default parameter values
    localparam int NOTE_COUNT_DEF  = 128;
    localparam int DIVISOR_MAX_DEF = 65535;
    localparam int COUNT_BITS_DEF  = 24;

    // Shared divider widths: 24-bit dividend, 16-bit divisor
    localparam int DIV_NW = 24;
    localparam int DIV_DW = 16;

    // Note table size
    localparam int NOTE_ROM_SIZE = 128;

    localparam logic [15:0] NOTE_ROM [NOTE_ROM_SIZE] = '{
        16'd8, 16'd9, 16'd9, 16'd10, 16'd10, 16'd11, 16'd12, 16'd12,
        16'd13, 16'd14, 16'd15, 16'd15, 16'd16, 16'd17, 16'd18, 16'd19,
        16'd21, 16'd22, 16'd23, 16'd25, 16'd26, 16'd28, 16'd29, 16'd31,
        16'd33, 16'd35, 16'd37, 16'd39, 16'd41, 16'd44, 16'd46, 16'd49,
        16'd52, 16'd55, 16'd58, 16'd62, 16'd65, 16'd69, 16'd73, 16'd78,
        16'd82, 16'd87, 16'd93, 16'd98, 16'd104, 16'd110, 16'd117, 16'd123,
        16'd131, 16'd139, 16'd147, 16'd156, 16'd165, 16'd175, 16'd185, 16'd196,
        16'd208, 16'd220, 16'd233, 16'd247, 16'd262, 16'd277, 16'd294, 16'd311,
        16'd330, 16'd349, 16'd370, 16'd392, 16'd415, 16'd440, 16'd466, 16'd494,
        16'd523, 16'd554, 16'd587, 16'd622, 16'd659, 16'd698, 16'd740, 16'd784,
        16'd831, 16'd880, 16'd932, 16'd988, 16'd1047, 16'd1109, 16'd1175, 16'd1245,
        16'd1319, 16'd1397, 16'd1480, 16'd1568, 16'd1661, 16'd1760, 16'd1865, 16'd1976,
        16'd2093, 16'd2217, 16'd2349, 16'd2489, 16'd2637, 16'd2794, 16'd2960, 16'd3136,
        16'd3322, 16'd3520, 16'd3729, 16'd3951, 16'd4186, 16'd4435, 16'd4699, 16'd4978,
        16'd5274, 16'd5588, 16'd5920, 16'd6272, 16'd6645, 16'd7040, 16'd7459, 16'd7902,
        16'd8372, 16'd8870, 16'd9397, 16'd9956, 16'd10548, 16'd11175, 16'd11840, 16'd12544
    };

    // Controller to datapath commands
    typedef struct packed {
        logic load_cmd;
        logic start_tone;
        logic start_tick;
        logic cap_tone;
        logic cap_tick;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_tone;
        logic need_tick;
        logic div_busy;
        logic div_done;
    } t_dp_status;

endpackage
`default_nettype wire

### src/tcc_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module tcc_div #(
    parameter int NW = tcc_pkg::DIV_NW,
    parameter int DW = tcc_pkg::DIV_DW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_busy,
    output logic               o_done,
    output logic [NW-1:0]      o_quo,
    output logic [DW-1:0]      o_rem
);
    localparam int CW = (NW > 1) ? $clog2(NW) : 1;
    localparam logic [CW-1:0] LAST = CW'(NW - 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic [DW:0]   w_sh;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // Trial subtract of the shifted partial remainder
    always_comb begin
        w_sh   = {r_rem, r_quo[NW-1]};
        w_diff = w_sh - {1'b0, r_d};
        w_ge   = (w_sh >= {1'b0, r_d});
    end

    // Control: run NW steps after start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: load operands, then shift in one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            r_quo <= {r_quo[NW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

### src/tcc_datapath.sv
// Command, configuration and tone state registers with the shared divider.
`default_nettype none
module tcc_datapath #(
    parameter int NOTE_COUNT  = tcc_pkg::NOTE_COUNT_DEF,
    parameter int DIVISOR_MAX = tcc_pkg::DIVISOR_MAX_DEF,
    parameter int COUNT_BITS  = tcc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tcc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tcc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic [2:0]                      i_action,
    input  wire logic [15:0]                     i_freq_hz,
    input  wire logic [23:0]                     i_duration_ms,
    input  wire logic [7:0]                      i_note,
    input  wire tcc_pkg::t_dp_cmd                i_cmd,
    output tcc_pkg::t_dp_status                  o_status_bus,
    output logic [15:0]                          o_divisor,
    output logic                                 o_divisor_loaded,
    output logic                                 o_gate_on,
    output logic                                 o_timed_active,
    output logic                                 o_status
);
    localparam int NW = tcc_pkg::DIV_NW;
    localparam int DW = tcc_pkg::DIV_DW;
    localparam int TW = (COUNT_BITS > NW + 1) ? COUNT_BITS : NW + 1;
    localparam logic [TW-1:0] CMAX = TW'((64'd1 << COUNT_BITS) - 64'd1);

    // Configuration registers
    logic [23:0] r_ref_clock;
    logic [15:0] r_max_tone;
    logic [15:0] r_beep_hz;
    logic [15:0] r_beep_ms;
    logic [9:0]  r_tick_ms;

    // Latched command word
    logic [2:0]  r_act;
    logic [15:0] r_freq;
    logic [23:0] r_dur;
    logic [7:0]  r_note;

    // Tone state
    logic [15:0]           r_div;
    logic                  r_gate;
    logic [COUNT_BITS-1:0] r_ticks;

    // Staged division results
    logic [15:0]           r_q;
    logic [COUNT_BITS-1:0] r_t;

    // Output word
    logic [15:0] r_o_div;
    logic        r_o_loaded;
    logic        r_o_gate;
    logic        r_o_timed;
    logic        r_o_status;

    logic        w_note_ok;
    logic [15:0] w_nf;
    logic [15:0] w_tone_f;
    logic [23:0] w_ms;
    logic [9:0]  w_tm;
    logic        w_tone_act;
    logic        w_tone_ok;
    logic        w_timed;
    logic        w_clear_ticks;

    logic          w_div_start;
    logic [NW-1:0] w_div_n;
    logic [DW-1:0] w_div_d;
    logic          w_div_busy;
    logic          w_div_done;
    logic [NW-1:0] w_div_quo;
    logic [DW-1:0] w_div_rem;

    logic [15:0]           n_q;
    logic [TW-1:0]         w_tc;
    logic [TW-1:0]         w_tsat;
    logic [15:0]           n_div;
    logic                  n_gate;
    logic [COUNT_BITS-1:0] n_ticks;
    logic                  n_loaded;
    logic                  n_status;

    // Decode the latched command
    always_comb begin
        w_note_ok = ({1'b0, r_note} < 9'(NOTE_COUNT)) && !r_note[7];
        w_nf      = w_note_ok ? tcc_pkg::NOTE_ROM[r_note[6:0]] : 16'd0;
        w_tm      = (r_tick_ms == 10'd0) ? 10'd1 : r_tick_ms;
        w_tone_f      = r_freq;
        w_ms          = r_dur;
        w_tone_act    = 1'b0;
        w_timed       = 1'b0;
        w_clear_ticks = 1'b0;
        unique case (r_act)
            tcc_pkg::ACT_PLAY: begin
                w_tone_act    = 1'b1;
                w_clear_ticks = 1'b1;
            end
            tcc_pkg::ACT_STOP: begin
                w_clear_ticks = 1'b1;
            end
            tcc_pkg::ACT_BEEP: begin
                w_tone_f   = (r_freq == 16'd0) ? r_beep_hz : r_freq;
                w_ms       = (r_dur == 24'd0) ? {8'd0, r_beep_ms} : r_dur;
                w_tone_act = 1'b1;
                w_timed    = 1'b1;
            end
            tcc_pkg::ACT_NOTE: begin
                w_tone_f = w_nf;
                if (r_dur == 24'd0) begin
                    w_tone_act    = 1'b1;
                    w_clear_ticks = 1'b1;
                end else if (w_nf != 16'd0) begin
                    w_tone_act = 1'b1;
                    w_timed    = 1'b1;
                end
            end
            default: begin
            end
        endcase
        w_tone_ok = w_tone_act && (w_tone_f != 16'd0) && (w_tone_f <= r_max_tone);
    end

    // Divider operands: tick count when asked, tone divisor otherwise
    always_comb begin
        w_div_start = i_cmd.start_tone || i_cmd.start_tick;
        if (i_cmd.start_tick) begin
            w_div_n = w_ms;
            w_div_d = {6'd0, w_tm};
        end else begin
            w_div_n = r_ref_clock;
            w_div_d = w_tone_f;
        end
    end

    tcc_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_n),
        .i_divisor  (w_div_d),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quo      (w_div_quo),
        .o_rem      (w_div_rem)
    );

    // Clamp the tone divisor and round up the tick count
    always_comb begin
        if (w_div_quo > NW'(DIVISOR_MAX)) begin
            n_q = 16'(DIVISOR_MAX);
        end else if (w_div_quo == '0) begin
            n_q = 16'd1;
        end else begin
            n_q = w_div_quo[15:0];
        end
        w_tc = TW'(w_div_quo) + TW'(w_div_rem != '0);
        if (w_tc == '0) begin
            w_tsat = TW'(1);
        end else if (w_tc > CMAX) begin
            w_tsat = CMAX;
        end else begin
            w_tsat = w_tc;
        end
    end

    // Next tone state for the command being finished
    always_comb begin
        n_div    = r_div;
        n_gate   = r_gate;
        n_ticks  = r_ticks;
        n_loaded = 1'b0;
        n_status = 1'b0;
        priority if (r_act == tcc_pkg::ACT_TICK) begin
            if (r_ticks != '0) begin
                n_ticks = r_ticks - 1'b1;
                if (r_ticks == COUNT_BITS'(1)) begin
                    n_gate = 1'b0;
                end
            end
        end else if (r_act > tcc_pkg::ACT_TICK) begin
            n_status = 1'b1;
        end else begin
            if (w_clear_ticks) begin
                n_ticks = '0;
            end
            if (w_timed) begin
                n_ticks = r_t;
            end
            if (r_act == tcc_pkg::ACT_STOP) begin
                n_gate = 1'b0;
            end
            if (w_tone_act) begin
                if (w_tone_ok) begin
                    n_div    = r_q;
                    n_loaded = 1'b1;
                    n_gate   = 1'b1;
                end else begin
                    n_gate = 1'b0;
                end
            end
        end
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_clock <= tcc_pkg::REF_CLOCK_RST;
            r_max_tone  <= tcc_pkg::MAX_TONE_RST;
            r_beep_hz   <= tcc_pkg::BEEP_HZ_RST;
            r_beep_ms   <= tcc_pkg::BEEP_MS_RST;
            r_tick_ms   <= tcc_pkg::TICK_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcc_pkg::CFG_REF_CLOCK: r_ref_clock <= i_cfg_wdata[23:0];
                tcc_pkg::CFG_MAX_TONE:  r_max_tone  <= i_cfg_wdata[15:0];
                tcc_pkg::CFG_BEEP_HZ:   r_beep_hz   <= i_cfg_wdata[15:0];
                tcc_pkg::CFG_BEEP_MS:   r_beep_ms   <= i_cfg_wdata[15:0];
                tcc_pkg::CFG_TICK_MS:   r_tick_ms   <= i_cfg_wdata[9:0];
                default: begin
                end
            endcase
        end
    end

    // Tone state update on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div   <= '0;
            r_gate  <= 1'b0;
            r_ticks <= '0;
        end else if (i_cmd.commit) begin
            r_div   <= n_div;
            r_gate  <= n_gate;
            r_ticks <= n_ticks;
        end
    end

    // Payload registers: command word, staged results, output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cmd) begin
            r_act  <= i_action;
            r_freq <= i_freq_hz;
            r_dur  <= i_duration_ms;
            r_note <= i_note;
        end
        if (i_cmd.cap_tone) begin
            r_q <= n_q;
        end
        if (i_cmd.cap_tick) begin
            r_t <= COUNT_BITS'(w_tsat);
        end
        if (i_cmd.commit) begin
            r_o_div    <= n_div;
            r_o_loaded <= n_loaded;
            r_o_gate   <= n_gate;
            r_o_timed  <= (n_ticks != '0);
            r_o_status <= n_status;
        end
    end

    always_comb begin
        o_status_bus.need_tone = w_tone_ok;
        o_status_bus.need_tick = w_timed;
        o_status_bus.div_busy  = w_div_busy;
        o_status_bus.div_done  = w_div_done;
    end

    assign o_divisor        = r_o_div;
    assign o_divisor_loaded = r_o_loaded;
    assign o_gate_on        = r_o_gate;
    assign o_timed_active   = r_o_timed;
    assign o_status         = r_o_status;
endmodule
`default_nettype wire

### src/tcc_ctrl.sv
// Sequencer for one command: decode, up to two divisions, then result handoff.
`default_nettype none
module tcc_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    input  wire tcc_pkg::t_dp_status i_st,
    output tcc_pkg::t_dp_cmd         o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_DIV2 = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_cmd = 1'b1;
                    n_state        = S_DEC;
                end
            end
            S_DEC: begin
                priority if (i_st.need_tone) begin
                    o_cmd.start_tone = 1'b1;
                    n_state          = S_DIV1;
                end else if (i_st.need_tick) begin
                    o_cmd.start_tick = 1'b1;
                    n_state          = S_DIV2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV1: begin
                if (i_st.div_done) begin
                    o_cmd.cap_tone = 1'b1;
                    if (i_st.need_tick) begin
                        o_cmd.start_tick = 1'b1;
                        n_state          = S_DIV2;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV2: begin
                if (i_st.div_done) begin
                    o_cmd.cap_tick = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result word until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

### src/tone_command_controller_top.sv
// Top level of the tone command controller: sequencer, datapath and checks.
//
//  channel   signals                                       handshake
//  --------  --------------------------------------------  -------------------------
//  command   i_action i_freq_hz i_duration_ms i_note       i_in_valid / o_in_ready
//  result    o_divisor o_divisor_loaded o_gate_on          o_out_valid / i_out_ready
//            o_timed_active o_status
//  config    i_cfg_idx i_cfg_wdata                         i_cfg_we (no wait)
//
// One command word at a time. Stop, tick, invalid and out-of-range play words
// need no division; an in-range play needs one, as does a beep or timed note whose
// tone is out of range; a beep or timed note that sounds needs two. The shared
// 24-step serial divider serves both: one pass for the timer divisor, one for the
// tick count. Reset is synchronous and needs no clearing pass.
// A stalled result sits in the output register; the next word is taken the cycle
// after the following result has been written there.
`default_nettype none
module tone_command_controller_top #(
    parameter int NOTE_COUNT  = tcc_pkg::NOTE_COUNT_DEF,
    parameter int DIVISOR_MAX = tcc_pkg::DIVISOR_MAX_DEF,
    parameter int COUNT_BITS  = tcc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tcc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tcc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [2:0]                      i_action,
    input  wire logic [15:0]                     i_freq_hz,
    input  wire logic [23:0]                     i_duration_ms,
    input  wire logic [7:0]                      i_note,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [15:0]                          o_divisor,
    output logic                                 o_divisor_loaded,
    output logic                                 o_gate_on,
    output logic                                 o_timed_active,
    output logic                                 o_status
);
    tcc_pkg::t_dp_cmd    w_cmd;
    tcc_pkg::t_dp_status w_st;

    tcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_st        (w_st),
        .o_cmd       (w_cmd)
    );

    tcc_datapath #(
        .NOTE_COUNT  (NOTE_COUNT),
        .DIVISOR_MAX (DIVISOR_MAX),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_action         (i_action),
        .i_freq_hz        (i_freq_hz),
        .i_duration_ms    (i_duration_ms),
        .i_note           (i_note),
        .i_cmd            (w_cmd),
        .o_status_bus     (w_st),
        .o_divisor        (o_divisor),
        .o_divisor_loaded (o_divisor_loaded),
        .o_gate_on        (o_gate_on),
        .o_timed_active   (o_timed_active),
        .o_status         (o_status)
    );

    // One word in flight: after an accept the input side closes
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("command accepted while previous word in flight");

    // The divider is never restarted mid-run
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.start_tone || w_cmd.start_tick) |-> !w_st.div_busy)
        else $error("divider started while busy");

    // An invalid word never reprograms the divisor
    a_invalid_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> !o_divisor_loaded)
        else $error("invalid word reported a divisor load");

    // A fresh divisor is nonzero and turns the gate on
    a_load_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_divisor_loaded) |-> (o_gate_on && (o_divisor != 16'd0)))
        else $error("divisor load without gate or with zero divisor");
endmodule
`default_nettype wire

### tb/tcc_result_checker.sv
// Result checker for the tone command controller: tracks settings, predicts and compares words.
module tcc_result_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tcc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tcc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_ready,
    input  wire logic [2:0]                     i_action,
    input  wire logic [15:0]                    i_freq_hz,
    input  wire logic [23:0]                    i_duration_ms,
    input  wire logic [7:0]                     i_note,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic [15:0]                    i_divisor,
    input  wire logic                           i_divisor_loaded,
    input  wire logic                           i_gate_on,
    input  wire logic                           i_timed_active,
    input  wire logic                           i_status,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     NOTE_LIMIT  = tcc_pkg::NOTE_COUNT_DEF;
    localparam longint DIV_CEILING = tcc_pkg::DIVISOR_MAX_DEF;
    localparam int     TICK_BITS   = tcc_pkg::COUNT_BITS_DEF;
    localparam longint TICKS_SAT   = (64'd1 << TICK_BITS) - 1;
    localparam int     REPORT_MAX  = 10;

    typedef struct packed {
        logic [15:0] divisor;
        logic        loaded;
        logic        gate_on;
        logic        timed;
        logic        status;
    } t_tone_word;

    // Settings as the block holds them
    logic [23:0] ref_clk_cfg;
    logic [15:0] max_tone_cfg;
    logic [15:0] beep_hz_cfg;
    logic [15:0] beep_ms_cfg;
    logic [9:0]  tick_ms_cfg;

    // Speaker state as the block holds it
    logic [15:0]          divisor_now;
    logic                 gate_now;
    logic [TICK_BITS-1:0] ticks_now;
    logic                 loaded_now;

    t_tone_word expected_words[$];
    int         failures = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Program the divisor for a tone, or silence the gate when the tone is out of range
    function automatic void play_tone(input logic [15:0] hz);
        longint quot;
        if (hz == 0 || hz > max_tone_cfg) begin
            gate_now = 1'b0;
            return;
        end
        quot = ref_clk_cfg / hz;
        if (quot > DIV_CEILING)
            quot = DIV_CEILING;
        if (quot == 0)
            quot = 1;
        divisor_now = quot[15:0];
        loaded_now  = 1'b1;
        gate_now    = 1'b1;
    endfunction

    // Start a tone with a countdown of ceil(ms / tick) ticks, defaults for zero requests
    function automatic void start_timed_tone(input logic [15:0] hz, input logic [23:0] ms_req);
        longint tick_len;
        longint ms;
        longint span;
        tick_len = (tick_ms_cfg == 0) ? 1 : tick_ms_cfg;
        ms = (ms_req == 0) ? beep_ms_cfg : ms_req;
        play_tone((hz == 0) ? beep_hz_cfg : hz);
        span = (ms + tick_len - 1) / tick_len;
        if (span == 0)
            span = 1;
        if (span > TICKS_SAT)
            span = TICKS_SAT;
        ticks_now = span[TICK_BITS-1:0];
    endfunction

    // Advance the speaker state by one command and form the word it answers with
    function automatic t_tone_word apply_command(input logic [2:0] act, input logic [15:0] hz,
                                                 input logic [23:0] ms, input logic [7:0] nt);
        t_tone_word  word;
        logic [15:0] note_hz;
        word       = '0;
        loaded_now = 1'b0;
        case (act)
            tcc_pkg::ACT_PLAY: begin
                ticks_now = '0;
                play_tone(hz);
            end
            tcc_pkg::ACT_STOP: begin
                ticks_now = '0;
                gate_now  = 1'b0;
            end
            tcc_pkg::ACT_BEEP: begin
                start_timed_tone(hz, ms);
            end
            tcc_pkg::ACT_NOTE: begin
                note_hz = (nt < NOTE_LIMIT && nt < tcc_pkg::NOTE_ROM_SIZE)
                          ? tcc_pkg::NOTE_ROM[nt] : 16'd0;
                if (ms == 0) begin
                    ticks_now = '0;
                    play_tone(note_hz);
                end else if (note_hz != 0) begin
                    start_timed_tone(note_hz, ms);
                end
            end
            tcc_pkg::ACT_TICK: begin
                if (ticks_now != 0) begin
                    ticks_now = ticks_now - 1'b1;
                    if (ticks_now == 0)
                        gate_now = 1'b0;
                end
            end
            default: begin
                word.status = 1'b1;
            end
        endcase
        word.divisor = divisor_now;
        word.loaded  = loaded_now;
        word.gate_on = gate_now;
        word.timed   = (ticks_now != 0);
        return word;
    endfunction

    // Watch the channels: settings, result words, then command words
    always @(posedge i_clk) begin
        t_tone_word got;
        t_tone_word want;
        if (!i_rst_n) begin
            ref_clk_cfg  = tcc_pkg::REF_CLOCK_RST;
            max_tone_cfg = tcc_pkg::MAX_TONE_RST;
            beep_hz_cfg  = tcc_pkg::BEEP_HZ_RST;
            beep_ms_cfg  = tcc_pkg::BEEP_MS_RST;
            tick_ms_cfg  = tcc_pkg::TICK_MS_RST;
            divisor_now  = '0;
            gate_now     = 1'b0;
            ticks_now    = '0;
            loaded_now   = 1'b0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tcc_pkg::CFG_REF_CLOCK: ref_clk_cfg  = i_cfg_wdata[23:0];
                    tcc_pkg::CFG_MAX_TONE:  max_tone_cfg = i_cfg_wdata[15:0];
                    tcc_pkg::CFG_BEEP_HZ:   beep_hz_cfg  = i_cfg_wdata[15:0];
                    tcc_pkg::CFG_BEEP_MS:   beep_ms_cfg  = i_cfg_wdata[15:0];
                    tcc_pkg::CFG_TICK_MS:   tick_ms_cfg  = i_cfg_wdata[9:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.divisor = i_divisor;
                got.loaded  = i_divisor_loaded;
                got.gate_on = i_gate_on;
                got.timed   = i_timed_active;
                got.status  = i_status;
                if (expected_words.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_MAX) begin
                        $write("%0t: result word with none expected:", $time);
                        $display(" div=%0d ld=%b gate=%b tm=%b st=%b", got.divisor,
                                 got.loaded, got.gate_on, got.timed, got.status);
                    end
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        failures++;
                        if (failures <= REPORT_MAX) begin
                            $write("%0t: result mismatch:", $time);
                            $write(" expected div=%0d ld=%b gate=%b tm=%b st=%b,",
                                   want.divisor, want.loaded, want.gate_on, want.timed,
                                   want.status);
                            $display(" got div=%0d ld=%b gate=%b tm=%b st=%b",
                                     got.divisor, got.loaded, got.gate_on, got.timed,
                                     got.status);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_words.push_back(apply_command(i_action, i_freq_hz, i_duration_ms,
                                                       i_note));
        end
        o_fail_count <= failures;
        o_pending    <= expected_words.size();
    end

endmodule

### tb/tone_command_controller_top_test.sv
// Testbench top of the tone command controller: clock, reset, command stimulus and verdict.
module tone_command_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT    = 1_000_000;
    localparam int PHASE_WORDS  = 113;
    localparam int PHASE_COUNT  = 10;
    localparam int DRAIN_CYCLES = 60;

    // Action codes the block rejects, and a register index it does not decode
    localparam logic [2:0] ACT_BAD_FIRST = tcc_pkg::ACT_TICK + 3'd1;
    localparam logic [2:0] ACT_BAD_LAST  = 3'd7;
    localparam logic [tcc_pkg::CFG_IDX_W-1:0] CFG_SPARE = tcc_pkg::CFG_TICK_MS + 3'd1;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_SQUARE} t_rx_mode;

    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           i_cfg_we       = 1'b0;
    logic [tcc_pkg::CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [tcc_pkg::CFG_DATA_W-1:0] i_cfg_wdata    = '0;
    logic                           i_in_valid     = 1'b0;
    logic [2:0]                     i_action       = '0;
    logic [15:0]                    i_freq_hz      = '0;
    logic [23:0]                    i_duration_ms  = '0;
    logic [7:0]                     i_note         = '0;
    logic                           i_out_ready    = 1'b0;
    logic                           o_in_ready;
    logic                           o_out_valid;
    logic [15:0]                    o_divisor;
    logic                           o_divisor_loaded;
    logic                           o_gate_on;
    logic                           o_timed_active;
    logic                           o_status;

    int          fail_count;
    int          pending_count;
    int          cycle_count  = 0;
    int          burst_left   = 1;
    int          tick_span    = tcc_pkg::TICK_MS_RST;
    logic [15:0] max_tone_now = tcc_pkg::MAX_TONE_RST;
    t_rx_mode    rx_mode      = RX_OPEN;
    int          rx_left      = 0;

    tone_command_controller_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_freq_hz        (i_freq_hz),
        .i_duration_ms    (i_duration_ms),
        .i_note           (i_note),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_divisor        (o_divisor),
        .o_divisor_loaded (o_divisor_loaded),
        .o_gate_on        (o_gate_on),
        .o_timed_active   (o_timed_active),
        .o_status         (o_status)
    );

    tcc_result_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_freq_hz        (i_freq_hz),
        .i_duration_ms    (i_duration_ms),
        .i_note           (i_note),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_divisor        (o_divisor),
        .i_divisor_loaded (o_divisor_loaded),
        .i_gate_on        (o_gate_on),
        .i_timed_active   (o_timed_active),
        .i_status         (o_status),
        .o_fail_count     (fail_count),
        .o_pending        (pending_count)
    );

    always #2 i_clk = ~i_clk;

    // Stall the result channel on a pattern that is picked anew at random when its run ends
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(40, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_out_ready <= ($urandom_range(0, 5) == 0);
            default:   i_out_ready <= rx_left[3];
        endcase
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("** tone_command_controller_top: FAILED **");
            $finish;
        end
    end

    // Offer one command word and hold it until taken; drop valid and idle at the end of a burst
    task automatic send_word(input logic [2:0] act, input logic [15:0] hz,
                             input logic [23:0] ms, input logic [7:0] nt);
        int gap;
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_freq_hz     <= hz;
        i_duration_ms <= ms;
        i_note        <= nt;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 30);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
        end
    endtask

    // Hold the sender until every expected result word has come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // Write all five settings plus the undecoded index, one per cycle
    task automatic load_settings(input logic [23:0] ref_hz, input logic [23:0] max_hz,
                                 input logic [23:0] beep_hz, input logic [23:0] beep_ms,
                                 input logic [23:0] tick);
        logic [tcc_pkg::CFG_IDX_W-1:0]  regs[6];
        logic [tcc_pkg::CFG_DATA_W-1:0] vals[6];
        regs = '{tcc_pkg::CFG_REF_CLOCK, tcc_pkg::CFG_MAX_TONE, tcc_pkg::CFG_BEEP_HZ,
                 tcc_pkg::CFG_BEEP_MS, tcc_pkg::CFG_TICK_MS, CFG_SPARE};
        vals = '{ref_hz, max_hz, beep_hz, beep_ms, tick, 24'($urandom)};
        for (int k = 0; k < 6; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= regs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        max_tone_now = max_hz[15:0];
        tick_span    = (tick[9:0] == 0) ? 1 : int'(tick[9:0]);
    endtask

    // Pick one random command, weighted toward ticks, then beeps
    task automatic send_random_word();
        int          pick;
        logic [2:0]  act;
        logic [15:0] hz;
        logic [23:0] ms;
        logic [7:0]  nt;
        hz   = 16'($urandom);
        ms   = 24'($urandom);
        nt   = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            act = tcc_pkg::ACT_PLAY;
            case ($urandom_range(0, 3))
                0: hz = '0;
                1: hz = 16'($urandom_range(1, max_tone_now));
                2: hz = max_tone_now + 16'd1;
                default: ;
            endcase
        end else if (pick < 20) begin
            act = tcc_pkg::ACT_STOP;
        end else if (pick < 38) begin
            act = tcc_pkg::ACT_BEEP;
            case ($urandom_range(0, 3))
                0: hz = '0;
                1, 2: hz = 16'($urandom_range(1, max_tone_now));
                default: ;
            endcase
            case ($urandom_range(0, 4))
                0: ms = '0;
                4: ;
                default: ms = 24'($urandom_range(1, tick_span * 6));
            endcase
        end else if (pick < 52) begin
            act = tcc_pkg::ACT_NOTE;
            nt  = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(128, 255))
                                              : 8'($urandom_range(0, 127));
            case ($urandom_range(0, 5))
                0, 1: ms = '0;
                5: ;
                default: ms = 24'($urandom_range(1, tick_span * 6));
            endcase
        end else if (pick < 93) begin
            act = tcc_pkg::ACT_TICK;
        end else begin
            act = 3'($urandom_range(ACT_BAD_FIRST, ACT_BAD_LAST));
        end
        send_word(act, hz, ms, nt);
    endtask

    initial begin
        burst_left = $urandom_range(1, 12);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed commands under reset settings
        send_word(tcc_pkg::ACT_TICK, '0, '0, '0);            // tick with no countdown
        send_word(tcc_pkg::ACT_STOP, '1, '1, '1);
        send_word(tcc_pkg::ACT_PLAY, '0, '0, '0);            // zero frequency silences
        send_word(tcc_pkg::ACT_PLAY, 16'd440, '0, '0);
        send_word(tcc_pkg::ACT_PLAY, '1, '0, '0);            // above the limit keeps divisor
        send_word(tcc_pkg::ACT_PLAY, tcc_pkg::MAX_TONE_RST, '0, '0);
        send_word(tcc_pkg::ACT_PLAY, 16'd1, '0, '0);         // quotient clamps high
        send_word(tcc_pkg::ACT_BEEP, '0, '0, '0);            // default tone and length
        send_word(tcc_pkg::ACT_BEEP, 16'd1000, 24'd25, '0);  // replaces running countdown
        repeat (4) send_word(tcc_pkg::ACT_TICK, '1, '1, '1); // expire, then idle tick
        send_word(tcc_pkg::ACT_BEEP, '1, '1, '0);            // gate off, countdown still loaded
        send_word(tcc_pkg::ACT_NOTE, '0, '0, 8'd69);         // continuous note
        send_word(tcc_pkg::ACT_NOTE, '0, '0, 8'd0);
        send_word(tcc_pkg::ACT_NOTE, '0, '0, 8'd127);
        send_word(tcc_pkg::ACT_NOTE, '0, 24'd10, 8'd60);     // timed note, one tick
        send_word(tcc_pkg::ACT_NOTE, '0, 24'd5, 8'd200);     // bad note with length: no change
        send_word(tcc_pkg::ACT_TICK, '0, '0, '0);
        send_word(tcc_pkg::ACT_NOTE, '0, '0, 8'd128);        // bad continuous note stops
        send_word(ACT_BAD_FIRST, '1, '1, '1);
        send_word(ACT_BAD_LAST, '0, '0, '0);

        // Random phases, each under its own settings
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_idle();
            case (phase)
                0: ;
                1: load_settings(24'hFFFFFF, 24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 24'h0003FF);
                2: load_settings(24'd1, 24'd1, 24'd1, 24'd1, 24'd1);
                3: load_settings('0, '0, '0, '0, '0);
                4: load_settings(tcc_pkg::REF_CLOCK_RST, 24'(tcc_pkg::MAX_TONE_RST),
                                 24'(tcc_pkg::BEEP_HZ_RST), 24'(tcc_pkg::BEEP_MS_RST),
                                 24'(tcc_pkg::TICK_MS_RST));
                default: load_settings(24'($urandom), 24'($urandom), 24'($urandom),
                                       24'($urandom), 24'($urandom_range(0, 40)));
            endcase
            repeat (PHASE_WORDS) send_random_word();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("** tone_command_controller_top: PASSED **");
        else
            $display("** tone_command_controller_top: FAILED **");
        $finish;
    end

endmodule

### sim.f
src/tcc_pkg.sv
src/tcc_div.sv
src/tcc_datapath.sv
src/tcc_ctrl.sv
src/tone_command_controller_top.sv
tb/tcc_result_checker.sv
tb/tone_command_controller_top_test.sv
